FILE: design/kpscd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the keypad code table for the keypad scanner.
// No dependencies; used by every module of the block.
package kpscd_pkg;

   // Input word opcodes.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_PRESS = 2'd1;
   localparam logic [1:0] OP_ROW   = 2'd2;

   // Configuration register word indexes.
   localparam logic REG_HOLD_TICKS = 1'b0;
   localparam logic REG_COUNT_TOP  = 1'b1;

   localparam logic [3:0] HOLD_TICKS_RESET = 4'd5;
   localparam logic [3:0] COUNT_TOP_RESET  = 4'd9;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Key codes, row-major, index is {row, column}.
   localparam logic [3:0] KEY_TABLE [16] = '{
      4'h1, 4'h2, 4'h3, 4'hA,
      4'h4, 4'h5, 4'h6, 4'hB,
      4'h7, 4'h8, 4'h9, 4'hC,
      4'hF, 4'h0, 4'hE, 4'hD
   };

   typedef struct packed {
      logic [1:0] opcode;
      logic [3:0] row_levels;
   } req_word_type;

   typedef struct packed {
      logic [3:0] column_drive;
      logic       scan_busy;
      logic       key_found;
      logic [3:0] display_value;
   } rsp_word_type;

   // What the scan unit reports for the word it is handed.
   typedef struct packed {
      logic [3:0] column_drive;
      logic       scan_busy;
      logic       key_found;
      logic [3:0] key_code;
   } scan_result_type;

   function automatic logic [3:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
      return KEY_TABLE[{row, col}];
   endfunction

endpackage

FILE: design/kpscd_scan.sv
`timescale 1ns / 1ps
// Column scan sequencer: walks the columns, finds the lowest pressed row
// and looks up the key code. Depends on kpscd_pkg.
module kpscd_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic [1:0]                 opcode,
   input  logic [3:0]                 row_levels,
   output kpscd_pkg::scan_result_type result
);

   logic       scanning_ff;
   logic       scanning_in;
   logic [1:0] column_ff;
   logic [1:0] column_in;
   logic [1:0] row_sel;
   logic       row_hit;
   logic       found;

   // Lowest row pulled low wins.
   always_comb begin
      row_hit = (row_levels != 4'hF);
      if (!row_levels[0]) begin
         row_sel = 2'd0;
      end else if (!row_levels[1]) begin
         row_sel = 2'd1;
      end else if (!row_levels[2]) begin
         row_sel = 2'd2;
      end else begin
         row_sel = 2'd3;
      end
   end

   always_comb begin
      scanning_in = scanning_ff;
      column_in   = column_ff;
      found       = 1'b0;
      case (opcode)
         kpscd_pkg::OP_PRESS: begin
            scanning_in = 1'b1;
            column_in   = 2'd0;
         end
         kpscd_pkg::OP_ROW: begin
            if (scanning_ff) begin
               if (row_hit) begin
                  found       = 1'b1;
                  scanning_in = 1'b0;
                  column_in   = 2'd0;
               end else if (column_ff == 2'd3) begin
                  scanning_in = 1'b0;
                  column_in   = 2'd0;
               end else begin
                  column_in = column_ff + 2'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.column_drive = scanning_in ? ~(4'b0001 << column_in) : 4'b0000;
      result.scan_busy    = scanning_in;
      result.key_found    = found;
      result.key_code     = kpscd_pkg::key_lookup(row_sel, column_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scanning_ff <= 1'b0;
         column_ff   <= 2'd0;
      end else if (enable) begin
         scanning_ff <= scanning_in;
         column_ff   <= column_in;
      end
   end

endmodule

FILE: design/keypad_scan_with_counter_display.sv
`timescale 1ns / 1ps
// Top level of the 4x4 keypad scanner with counter display.
// Depends on kpscd_pkg and kpscd_scan.
//
//   channel  direction  ports                               carries
//   req      in         req_valid, req_stall, req_word      opcode and row levels
//   rsp      out        rsp_valid, rsp_stall, rsp_word      columns, busy, found, display
//   csr      in/out     csr_psel .. csr_pready (APB-style)  hold_ticks, count_top
//
// Every word gives exactly one result word, offered on rsp once it has passed
// the input register and the result register; a new word can be accepted in
// every cycle while rsp is not stalled, the rate being set by the single pass
// of tick, scan and display logic between the input register and the result
// register. Reset is synchronous, clears the valid flags and the scan, tick,
// hold and display state, and restores the register defaults (hold 5 ticks,
// count top 9). A stall on rsp holds the result register, and one more word
// still enters the input register before req_stall rises.
module keypad_scan_with_counter_display (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  kpscd_pkg::req_word_type             req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output kpscd_pkg::rsp_word_type             rsp_word,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [kpscd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [kpscd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [kpscd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   // Configuration registers. Only the word index bit of the address is
   // decoded, so each register answers at its word address.
   logic [3:0] hold_ticks_ff;
   logic [3:0] count_top_ff;
   logic       csr_write;
   logic       csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= kpscd_pkg::HOLD_TICKS_RESET;
         count_top_ff  <= kpscd_pkg::COUNT_TOP_RESET;
      end else if (csr_write) begin
         if (csr_index == kpscd_pkg::REG_HOLD_TICKS) begin
            hold_ticks_ff <= csr_pwdata[3:0];
         end else begin
            count_top_ff <= csr_pwdata[3:0];
         end
      end
   end

   always_comb begin
      if (csr_index == kpscd_pkg::REG_HOLD_TICKS) begin
         csr_prdata = {{(kpscd_pkg::CSR_DATA_W-4){1'b0}}, hold_ticks_ff};
      end else begin
         csr_prdata = {{(kpscd_pkg::CSR_DATA_W-4){1'b0}}, count_top_ff};
      end
   end

   // Input register. It loads whenever it is empty or its word moves on to
   // the result register, so a waiting result does not block one new word.
   logic                    in_valid_ff;
   logic                    in_valid_in;
   kpscd_pkg::req_word_type in_word_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   kpscd_pkg::rsp_word_type rsp_word_ff;
   kpscd_pkg::rsp_word_type rsp_word_in;
   logic                    advance;
   logic                    accept;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
   end

   // Scan sequencer; its state moves only when the word moves on.
   kpscd_pkg::scan_result_type scan_result;

   kpscd_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .enable     (advance),
      .opcode     (in_word_ff.opcode),
      .row_levels (in_word_ff.row_levels),
      .result     (scan_result)
   );

   // Tick counter, key hold and display value.
   logic [3:0] tick_count_ff;
   logic [3:0] tick_count_in;
   logic [3:0] hold_left_ff;
   logic [3:0] hold_left_in;
   logic [3:0] held_key_ff;
   logic [3:0] held_key_in;
   logic [3:0] shown_value_ff;
   logic [3:0] shown_value_in;
   logic [3:0] tick_next;

   // A counter above a lowered top wraps to zero on the next tick.
   assign tick_next = (tick_count_ff < count_top_ff) ? tick_count_ff + 4'd1 : 4'd0;

   always_comb begin
      tick_count_in  = tick_count_ff;
      hold_left_in   = hold_left_ff;
      held_key_in    = held_key_ff;
      shown_value_in = shown_value_ff;
      if (in_word_ff.opcode == kpscd_pkg::OP_TICK) begin
         tick_count_in = tick_next;
         if (hold_left_ff != 4'd0) begin
            shown_value_in = held_key_ff;
            hold_left_in   = hold_left_ff - 4'd1;
         end else begin
            shown_value_in = tick_next;
         end
      end else if (scan_result.key_found) begin
         // A hold of zero stores the key but never shows it.
         held_key_in  = scan_result.key_code;
         hold_left_in = hold_ticks_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff  <= 4'd0;
         hold_left_ff   <= 4'd0;
         held_key_ff    <= 4'd0;
         shown_value_ff <= 4'd0;
      end else if (advance) begin
         tick_count_ff  <= tick_count_in;
         hold_left_ff   <= hold_left_in;
         held_key_ff    <= held_key_in;
         shown_value_ff <= shown_value_in;
      end
   end

   // Result register.
   always_comb begin
      rsp_word_in.column_drive  = scan_result.column_drive;
      rsp_word_in.scan_busy     = scan_result.scan_busy;
      rsp_word_in.key_found     = scan_result.key_found;
      rsp_word_in.display_value = shown_value_in;
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: design/kpscd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the keypad scanner, bound to the top level.
// Depends on kpscd_pkg.
module kpscd_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input kpscd_pkg::rsp_word_type rsp_word
);

   // No result is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A found key ends the scan, so the columns return to idle.
   a_found_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.key_found) |->
         (!rsp_word.scan_busy && rsp_word.column_drive == 4'b0000))
      else $error("key found while scan still busy");

   // Idle columns are all low, a scanning pattern drives exactly one low.
   a_column_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.scan_busy ? $onehot(~rsp_word.column_drive)
                                         : (rsp_word.column_drive == 4'b0000)))
      else $error("column pattern does not match scan state");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result changed");

endmodule

bind keypad_scan_with_counter_display kpscd_checker u_kpscd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
